// File: hdl/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants for the distance-vector route table core:
// request and result layouts, table entry layout, status codes and states.
// ----------------------------------------------------------------------------
package dvrt_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // configuration
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ADDRESS    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNREACH_COST   = 1'd1;
   localparam logic [15:0]          DEFAULT_UNREACH_COST = 16'd10000;

   // request modes
   localparam logic [1:0] MODE_LINK   = 2'd0;
   localparam logic [1:0] MODE_ADVERT = 2'd1;
   localparam logic [1:0] MODE_LIST   = 2'd2;

   typedef enum logic [2:0] {
      STAT_LOADED     = 3'd0,
      STAT_FULL       = 3'd1,
      STAT_UPDATED    = 3'd2,
      STAT_NOT_BETTER = 3'd3,
      STAT_NO_DEST    = 3'd4,
      STAT_NO_NBR     = 3'd5,
      STAT_LISTED     = 3'd6,
      STAT_EMPTY      = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIRECT,
      S_REM_A,
      S_REM_B,
      S_ADV_D,
      S_ADV_N,
      S_LIST
   } state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] addr_a;
      logic [31:0] addr_b;
      logic [15:0] link_cost;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] entry_dest;
      logic [31:0] entry_hop;
      logic        hop_known;
      logic [15:0] entry_cost;
      logic        is_neighbour;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] hop;
      logic        hop_known;
      logic [15:0] cost;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        entry;
   } tbl_wr_type;

endpackage

// File: hdl/dvrt_table.sv
// ----------------------------------------------------------------------------
// dvrt_table
// Route entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module dvrt_table (
   input  logic                         clock,
   input  dvrt_pkg::tbl_wr_type         wr,
   input  logic [dvrt_pkg::IDX_W-1:0]   rd_addr,
   output dvrt_pkg::entry_type          rd_data
);
   import dvrt_pkg::*;

   entry_type mem_ff [TABLE_ENTRIES];
   entry_type rd_data_ff;

   // write one entry, read one entry per cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.entry;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/dvrt_seq.sv
// ----------------------------------------------------------------------------
// dvrt_seq
// Request sequencer: scans the table one entry per cycle through a single
// address comparator, then inserts, updates or reports under a small FSM.
// ----------------------------------------------------------------------------
module dvrt_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  dvrt_pkg::req_type           req_data,
   input  logic [31:0]                 own_addr,
   input  logic [15:0]                 unreach_cost,
   output logic                        rsp_strobe,
   output dvrt_pkg::rsp_type           rsp_data,
   output dvrt_pkg::tbl_wr_type        tbl_wr,
   output logic [dvrt_pkg::IDX_W-1:0]  rd_addr,
   input  dvrt_pkg::entry_type         rd_data
);
   import dvrt_pkg::*;

   // build a result from a table entry
   function automatic rsp_type rsp_from_entry(status_type s, entry_type e, logic l);
      rsp_type r;
      r.status       = s;
      r.entry_dest   = e.dest;
      r.entry_hop    = e.hop_known ? e.hop : 32'd0;
      r.hop_known    = e.hop_known;
      r.entry_cost   = e.cost;
      r.is_neighbour = e.hop_known && (e.hop == e.dest);
      r.last         = l;
      return r;
   endfunction

   // build a result that carries only an address
   function automatic rsp_type rsp_from_addr(status_type s, logic [31:0] a, logic l);
      rsp_type r;
      r.status       = s;
      r.entry_dest   = a;
      r.entry_hop    = 32'd0;
      r.hop_known    = 1'b0;
      r.entry_cost   = 16'd0;
      r.is_neighbour = 1'b0;
      r.last         = l;
      return r;
   endfunction

   state_type        state_ff, state_in;
   logic [31:0]      key_ff, key_in;
   logic [31:0]      b_ff, b_in;
   logic [15:0]      c_ff, c_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0] d_idx_ff, d_idx_in;
   entry_type        d_entry_ff, d_entry_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic        issue;
   logic        hit;
   logic        miss;
   logic        room;
   logic        list_last;
   logic [16:0] sum;

   // shared scan: one read issued and one address compared per cycle
   assign issue     = (state_ff != S_IDLE) && (scan_idx_ff < count_ff);
   assign hit       = pend_ff && (rd_data.dest == key_ff);
   assign miss      = !issue && !hit;
   assign room      = (count_ff != CNT_W'(TABLE_ENTRIES));
   assign list_last = ((CNT_W'(pend_idx_ff) + CNT_W'(1)) == count_ff);
   assign sum       = {1'b0, rd_data.cost} + {1'b0, c_ff};
   assign rd_addr   = scan_idx_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         scan_idx_ff   <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_idx_ff   <= scan_idx_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      key_ff      <= key_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      pend_idx_ff <= pend_idx_in;
      d_idx_ff    <= d_idx_in;
      d_entry_ff  <= d_entry_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      entry_type ent;
      ent           = '0;
      state_in      = state_ff;
      key_in        = key_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      count_in      = count_ff;
      d_idx_in      = d_idx_ff;
      d_entry_in    = d_entry_ff;
      scan_idx_in   = scan_idx_ff + CNT_W'(issue);
      pend_in       = issue;
      pend_idx_in   = scan_idx_ff[IDX_W-1:0];
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      tbl_wr        = '0;

      unique case (state_ff)
         S_IDLE: begin
            scan_idx_in = '0;
            pend_in     = 1'b0;
            if (start) begin
               b_in = req_data.addr_b;
               c_in = req_data.link_cost;
               key_in = req_data.addr_a;
               priority case (req_data.mode)
                  MODE_LINK: begin
                     priority if (req_data.addr_a == own_addr) begin
                        key_in   = req_data.addr_b;
                        state_in = S_DIRECT;
                     end else if (req_data.addr_b == own_addr) begin
                        state_in = S_DIRECT;
                     end else begin
                        state_in = S_REM_A;
                     end
                  end
                  MODE_ADVERT: begin
                     state_in = S_ADV_D;
                  end
                  MODE_LIST: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_data_in   = rsp_from_addr(STAT_EMPTY, 32'd0, 1'b1);
                     end else begin
                        state_in = S_LIST;
                     end
                  end
                  default: begin
                     // drop the unused mode
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // link to this node: overwrite or append the neighbour entry, or report a full table
         S_DIRECT: begin
            ent = '{dest: key_ff, hop: key_ff, hop_known: 1'b1, cost: c_ff};
            if (hit || miss) begin
               state_in      = S_IDLE;
               scan_idx_in   = '0;
               pend_in       = 1'b0;
               rsp_strobe_in = 1'b1;
               if (hit) begin
                  tbl_wr      = '{en: 1'b1, addr: pend_idx_ff, entry: ent};
                  rsp_data_in = rsp_from_entry(STAT_LOADED, ent, 1'b1);
               end else if (room) begin
                  tbl_wr      = '{en: 1'b1, addr: count_ff[IDX_W-1:0], entry: ent};
                  count_in    = count_ff + CNT_W'(1);
                  rsp_data_in = rsp_from_entry(STAT_LOADED, ent, 1'b1);
               end else begin
                  rsp_data_in = rsp_from_addr(STAT_FULL, key_ff, 1'b1);
               end
            end
         end

         // remote link ends: add each end if absent, or report a full table
         S_REM_A, S_REM_B: begin
            ent = '{dest: key_ff, hop: 32'd0, hop_known: 1'b0, cost: unreach_cost};
            if (hit || miss) begin
               scan_idx_in   = '0;
               pend_in       = 1'b0;
               rsp_strobe_in = 1'b1;
               if (hit) begin
                  rsp_data_in = rsp_from_entry(STAT_LOADED, rd_data, state_ff == S_REM_B);
               end else if (room) begin
                  tbl_wr      = '{en: 1'b1, addr: count_ff[IDX_W-1:0], entry: ent};
                  count_in    = count_ff + CNT_W'(1);
                  rsp_data_in = rsp_from_entry(STAT_LOADED, ent, state_ff == S_REM_B);
               end else begin
                  rsp_data_in = rsp_from_addr(STAT_FULL, key_ff, state_ff == S_REM_B);
               end
               if (state_ff == S_REM_A) begin
                  key_in   = b_ff;
                  state_in = S_REM_B;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         // advertisement: find the destination first
         S_ADV_D: begin
            if (hit) begin
               d_idx_in    = pend_idx_ff;
               d_entry_in  = rd_data;
               key_in      = b_ff;
               state_in    = S_ADV_N;
               scan_idx_in = '0;
               pend_in     = 1'b0;
            end else if (miss) begin
               state_in      = S_IDLE;
               scan_idx_in   = '0;
               pend_in       = 1'b0;
               rsp_strobe_in = 1'b1;
               rsp_data_in   = rsp_from_addr(STAT_NO_DEST, key_ff, 1'b1);
            end
         end

         // advertisement: find the neighbour, then compare costs
         S_ADV_N: begin
            ent = '{dest: d_entry_ff.dest, hop: b_ff, hop_known: 1'b1, cost: sum[15:0]};
            if (hit || miss) begin
               state_in      = S_IDLE;
               scan_idx_in   = '0;
               pend_in       = 1'b0;
               rsp_strobe_in = 1'b1;
               if (miss) begin
                  rsp_data_in = rsp_from_entry(STAT_NO_NBR, d_entry_ff, 1'b1);
               end else if (sum < {1'b0, d_entry_ff.cost}) begin
                  tbl_wr      = '{en: 1'b1, addr: d_idx_ff, entry: ent};
                  rsp_data_in = rsp_from_entry(STAT_UPDATED, ent, 1'b1);
               end else begin
                  rsp_data_in = rsp_from_entry(STAT_NOT_BETTER, d_entry_ff, 1'b1);
               end
            end
         end

         // listing: report each used entry as its read returns
         S_LIST: begin
            if (pend_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = rsp_from_entry(STAT_LISTED, rd_data, list_last);
               if (list_last) begin
                  state_in    = S_IDLE;
                  scan_idx_in = '0;
                  pend_in     = 1'b0;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// File: hdl/distance_vector_route_table_core.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_core
// Distance-vector route table with link loading, advertisement update and
// table listing.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A listing of an empty
// table and a request of the unused mode are settled in the cycle that takes
// them, so busy does not rise for them; for any other request busy stays high
// until its last result has been decided. Every result is shown on rsp_data
// for exactly one cycle with rsp_strobe high, one cycle after it is decided,
// and cannot be held off, so the receiver must take it at once. Each table
// search reads the entries in use in order, one entry per cycle, through the
// one registered read port and one address comparator. A link to this node
// takes one search; an advertisement takes one search for the destination
// and, when it is found, a second for the neighbour; a link between two other
// nodes takes two searches, the second over one more entry when the first end
// was added; a listing reads every entry in use. There is no clearing pass
// after reset: entries are used in order and only those below the fill count
// are read. Configuration registers are written through csr_we, csr_index and
// csr_wdata while busy is low, which the user must ensure; the block does not.
// ----------------------------------------------------------------------------
module distance_vector_route_table_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  dvrt_pkg::req_type                req_data,
   output logic                             rsp_strobe,
   output dvrt_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [dvrt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dvrt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dvrt_pkg::*;

   logic [31:0] own_addr_ff;
   logic [15:0] unreach_cost_ff;

   tbl_wr_type       tbl_wr;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;

   // hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff     <= 32'd0;
         unreach_cost_ff <= DEFAULT_UNREACH_COST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS:  own_addr_ff     <= csr_wdata[31:0];
            CSR_UNREACH_COST: unreach_cost_ff <= csr_wdata[15:0];
            default:          own_addr_ff     <= own_addr_ff;
         endcase
      end
   end

   dvrt_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .own_addr     (own_addr_ff),
      .unreach_cost (unreach_cost_ff),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data),
      .tbl_wr       (tbl_wr),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   dvrt_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
